/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, disabled during reset.
`define FSE_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication in the next cycle, disabled during reset.
`define FSE_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/fse_pkg.sv */
// Shared types and constants of the Fourier series evaluator.
`default_nettype none
package fse_pkg;

  // Request operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_IDX_BIAS  = 2'd0;
  localparam logic [1:0] CFG_IDX_TREND = 2'd1;

  // Phase constants, Q0.32 turns / Q0.30 quarter turns
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [30:0] ONE_Q30      = 31'h4000_0000;
  localparam logic [63:0] HALF_LSB     = 64'h0000_0000_2000_0000;

  // sin(pi/2 * x) coefficients, Q1.30, x^1 up to x^11
  localparam int unsigned NUM_COEF = 6;
  localparam logic [30:0] POLY_COEF [NUM_COEF] = '{
    31'd1686629713, 31'd693598668, 31'd85569306, 31'd5026995, 31'd172272, 31'd3864
  };

  // Trend clamp and result range
  localparam logic signed [64:0] TREND_HI = 65'sh0_4000_0000_0000_0000;
  localparam logic signed [64:0] TREND_LO = -TREND_HI;
  localparam logic signed [65:0] VAL_MAX  = 66'sh0_0000_7FFF_FFFF_FFFF;
  localparam logic signed [65:0] VAL_MIN  = -VAL_MAX - 66'sd1;

  // One stored term
  typedef struct packed {
    logic signed [31:0] amp;
    logic [31:0]        freq;
    logic [31:0]        phase;
  } term_t;

endpackage
`default_nettype wire

/* rtl/fse_term_mem.sv */
// Term store: synchronous memory with per-entry valid bits cleared at reset.
`default_nettype none
module fse_term_mem #(
  parameter int NUM_TERMS = 10,
  parameter int AW        = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           we,
  input  wire logic [AW-1:0]  waddr,
  input  wire fse_pkg::term_t wdata,
  input  wire logic           re,
  input  wire logic [AW-1:0]  raddr,
  output fse_pkg::term_t      rdata,
  output logic                rvalid,
  output logic                rcos
);

  fse_pkg::term_t mem [NUM_TERMS];
  logic [NUM_TERMS-1:0] vld;

  // Storage write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Valid bits: a never-written entry reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rdata <= vld[raddr] ? mem[raddr] : '0;
    rcos  <= ~raddr[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rvalid <= 1'b0;
    end else begin
      rvalid <= re;
    end
  end

endmodule
`default_nettype wire

/* rtl/fse_term_pipe.sv */
// Term pipeline: phase, quarter sine polynomial and amplitude scaling.
`default_nettype none
module fse_term_pipe (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_vld,
  input  wire fse_pkg::term_t     in_term,
  input  wire logic               in_cos,
  input  wire logic [31:0]        t,
  output logic                    out_vld,
  output logic signed [34:0]      out_term
);

  localparam int NH = fse_pkg::NUM_COEF - 1;

  // Stage 1: phase
  logic [63:0]        ft;
  logic [31:0]        s1_theta;
  logic signed [31:0] s1_amp;
  logic               s1_vld;
  // Stage 2: quadrant fold
  logic [30:0]        s2_x;
  logic [1:0]         s2_quad;
  logic signed [31:0] s2_amp;
  logic               s2_vld;
  // Stage 3: square
  logic [61:0]        xx;
  logic [30:0]        s3_u;
  logic [30:0]        s3_x;
  logic [1:0]         s3_quad;
  logic signed [31:0] s3_amp;
  logic               s3_vld;
  // Horner stages
  logic [30:0]        hp   [NH];
  logic [30:0]        hu   [NH];
  logic [30:0]        hx   [NH];
  logic [1:0]         hq   [NH];
  logic signed [31:0] ha   [NH];
  logic [NH-1:0]      hv;
  // Final polynomial step and sign
  logic [61:0]        px;
  logic [30:0]        mag_s;
  logic signed [31:0] s9_s;
  logic signed [31:0] s9_amp;
  logic               s9_vld;
  // Amplitude product
  logic signed [63:0] s10_prod;
  logic               s10_vld;
  // Rounding
  logic [63:0]        pmag;
  logic [33:0]        rmag;

  assign ft = 64'(in_term.freq) * 64'(t);

  always_ff @(posedge clk) begin
    s1_theta <= ft[31:0] + in_term.phase + (in_cos ? fse_pkg::QUARTER_TURN : 32'd0);
    s1_amp   <= in_term.amp;
  end

  always_ff @(posedge clk) begin
    s2_quad <= s1_theta[31:30];
    s2_x    <= s1_theta[30] ? fse_pkg::ONE_Q30 - {1'b0, s1_theta[29:0]}
                            : {1'b0, s1_theta[29:0]};
    s2_amp  <= s1_amp;
  end

  assign xx = 62'(s2_x) * 62'(s2_x);

  always_ff @(posedge clk) begin
    s3_u    <= xx[60:30];
    s3_x    <= s2_x;
    s3_quad <= s2_quad;
    s3_amp  <= s2_amp;
  end

  // Horner steps, one multiply per stage
  for (genvar i = 0; i < NH; i++) begin : g_horner
    logic [30:0]        p_in;
    logic [30:0]        u_in;
    logic [30:0]        x_in;
    logic [1:0]         q_in;
    logic signed [31:0] a_in;
    logic [61:0]        pu;
    logic [31:0]        pn;
    if (i == 0) begin : g_first
      assign p_in = fse_pkg::POLY_COEF[NH];
      assign u_in = s3_u;
      assign x_in = s3_x;
      assign q_in = s3_quad;
      assign a_in = s3_amp;
    end else begin : g_rest
      assign p_in = hp[i-1];
      assign u_in = hu[i-1];
      assign x_in = hx[i-1];
      assign q_in = hq[i-1];
      assign a_in = ha[i-1];
    end
    assign pu = 62'(p_in) * 62'(u_in);
    assign pn = 32'(fse_pkg::POLY_COEF[NH-1-i]) - pu[61:30];
    always_ff @(posedge clk) begin
      hp[i] <= pn[30:0];
      hu[i] <= u_in;
      hx[i] <= x_in;
      hq[i] <= q_in;
      ha[i] <= a_in;
    end
  end

  assign px    = 62'(hp[NH-1]) * 62'(hx[NH-1]);
  assign mag_s = px[60:30];

  always_ff @(posedge clk) begin
    s9_s   <= hq[NH-1][1] ? -$signed({1'b0, mag_s}) : $signed({1'b0, mag_s});
    s9_amp <= ha[NH-1];
  end

  always_ff @(posedge clk) begin
    s10_prod <= s9_amp * s9_s;
  end

  // Round half away from zero, Q.46 to Q16.16
  assign pmag = s10_prod[63] ? 64'(-s10_prod) : 64'(s10_prod);
  assign rmag = 34'((pmag + fse_pkg::HALF_LSB) >> 30);

  always_ff @(posedge clk) begin
    out_term <= s10_prod[63] ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
  end

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld  <= 1'b0;
      s2_vld  <= 1'b0;
      s3_vld  <= 1'b0;
      hv      <= '0;
      s9_vld  <= 1'b0;
      s10_vld <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      s1_vld  <= in_vld;
      s2_vld  <= s1_vld;
      s3_vld  <= s2_vld;
      hv      <= NH'({hv, s3_vld});
      s9_vld  <= hv[NH-1];
      s10_vld <= s9_vld;
      out_vld <= s10_vld;
    end
  end

endmodule
`default_nettype wire

/* rtl/fourier_series_evaluator_core.sv */
// Top level: request decode, term sequencer, accumulator and saturation.
//
// Channel   | Signals                                        | Handshake
// request   | op term_slot amplitude frequency phase_offset  | start && !busy
//           | time_req                                       |
// config    | cfg_index cfg_data                             | cfg_valid && cfg_ready
// result    | value saturated                                | done, one cycle
//
// A term write leaves busy low. An evaluation issues one memory read per
// term per cycle into an eleven-stage term pipeline whose outputs are
// accumulated, then the S_FINISH state saturates the sum. Reset is
// synchronous and clears the term store valid bits and the configuration
// registers at once.
// The result receiver cannot stall; done is strobed for one cycle.
`default_nettype none
module fourier_series_evaluator_core #(
  parameter int NUM_TERMS = 10
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               op,
  input  wire logic [3:0]         term_slot,
  input  wire logic signed [31:0] amplitude,
  input  wire logic [31:0]        frequency,
  input  wire logic [31:0]        phase_offset,
  input  wire logic [31:0]        time_req,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  output logic                    done,
  output logic signed [47:0]      value,
  output logic                    saturated
);

  localparam int AW = (NUM_TERMS > 1) ? $clog2(NUM_TERMS) : 1;
  localparam int CW = $clog2(NUM_TERMS + 1);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_FINISH} state_t;

  state_t              state;
  logic [CW-1:0]       issue_cnt;
  logic [CW-1:0]       out_cnt;
  logic [31:0]         t_reg;
  logic signed [31:0]  offset_bias;
  logic signed [31:0]  linear_trend;
  logic signed [64:0]  trend_prod;
  logic                trend_pend;
  logic signed [65:0]  acc;
  logic signed [64:0]  trend_clamp;

  logic                req_acc;
  logic                wr_en;
  logic [31:0]         slot_ext;
  logic                rd_en;
  fse_pkg::term_t      wr_term;
  fse_pkg::term_t      rd_term;
  logic                rd_vld;
  logic                rd_cos;
  logic                term_vld;
  logic signed [34:0]  term_val;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign req_acc   = start && !busy;
  assign slot_ext  = 32'(term_slot);
  assign wr_en     = req_acc && (op == fse_pkg::OP_WRITE) && (slot_ext < 32'(NUM_TERMS));
  assign rd_en     = (state == S_RUN) && (issue_cnt < CW'(NUM_TERMS));
  assign wr_term   = '{amp: amplitude, freq: frequency, phase: phase_offset};

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bias  <= '0;
      linear_trend <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fse_pkg::CFG_IDX_BIAS:  offset_bias  <= $signed(cfg_data);
        fse_pkg::CFG_IDX_TREND: linear_trend <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  fse_term_mem #(
    .NUM_TERMS (NUM_TERMS),
    .AW        (AW)
  ) u_mem (
    .clk    (clk),
    .rst    (rst),
    .we     (wr_en),
    .waddr  (slot_ext[AW-1:0]),
    .wdata  (wr_term),
    .re     (rd_en),
    .raddr  (issue_cnt[AW-1:0]),
    .rdata  (rd_term),
    .rvalid (rd_vld),
    .rcos   (rd_cos)
  );

  fse_term_pipe u_pipe (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (rd_vld),
    .in_term  (rd_term),
    .in_cos   (rd_cos),
    .t        (t_reg),
    .out_vld  (term_vld),
    .out_term (term_val)
  );

  // Trend product registered on an evaluate request
  always_ff @(posedge clk) begin
    if (req_acc && (op == fse_pkg::OP_EVAL)) begin
      trend_prod <= linear_trend * $signed({1'b0, time_req});
      t_reg      <= time_req;
    end
  end

  always_comb begin
    if (trend_prod > fse_pkg::TREND_HI) begin
      trend_clamp = fse_pkg::TREND_HI;
    end else if (trend_prod < fse_pkg::TREND_LO) begin
      trend_clamp = fse_pkg::TREND_LO;
    end else begin
      trend_clamp = trend_prod;
    end
  end

  // Accumulator
  always_ff @(posedge clk) begin
    if (req_acc && (op == fse_pkg::OP_EVAL)) begin
      acc <= 66'(offset_bias);
    end else if (trend_pend) begin
      acc <= acc + 66'(trend_clamp);
    end else if (term_vld) begin
      acc <= acc + 66'(term_val);
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      issue_cnt  <= '0;
      out_cnt    <= '0;
      trend_pend <= 1'b0;
      done       <= 1'b0;
    end else begin
      done       <= 1'b0;
      trend_pend <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req_acc && (op == fse_pkg::OP_EVAL)) begin
            state      <= S_RUN;
            issue_cnt  <= '0;
            out_cnt    <= '0;
            trend_pend <= 1'b1;
          end
        end
        S_RUN: begin
          if (rd_en) begin
            issue_cnt <= issue_cnt + 1'b1;
          end
          if (term_vld) begin
            out_cnt <= out_cnt + 1'b1;
            if (out_cnt == CW'(NUM_TERMS - 1)) begin
              state <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Saturation
  always_ff @(posedge clk) begin
    if (state == S_FINISH) begin
      if (acc > fse_pkg::VAL_MAX) begin
        value     <= fse_pkg::VAL_MAX[47:0];
        saturated <= 1'b1;
      end else if (acc < fse_pkg::VAL_MIN) begin
        value     <= fse_pkg::VAL_MIN[47:0];
        saturated <= 1'b1;
      end else begin
        value     <= acc[47:0];
        saturated <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/fse_checker.sv */
// Port-level checker for the evaluator core, with its bind.
`default_nettype none
`include "assert_macros.svh"
module fse_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               op,
  input wire logic               done,
  input wire logic signed [47:0] value,
  input wire logic               saturated
);

  `FSE_ASSERT_NXT(a_eval_busy, clk, rst, start && !busy && op, busy, "evaluate request did not raise busy")
  `FSE_ASSERT_NXT(a_write_idle, clk, rst, start && !busy && !op, !busy, "term write left core busy")
  `FSE_ASSERT_NXT(a_done_single, clk, rst, done, !done, "result strobed twice in a row")
  `FSE_ASSERT_IMP(a_done_busy, clk, rst, done, !$past(busy) == 1'b0, "result without evaluation")
  `FSE_ASSERT_IMP(a_sat_clamp, clk, rst, done && saturated, (value == 48'sh7FFF_FFFF_FFFF) || (value == -48'sh8000_0000_0000), "saturated value not at range limit")

endmodule

bind fourier_series_evaluator_core fse_checker u_fse_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .op        (op),
  .done      (done),
  .value     (value),
  .saturated (saturated)
);
`default_nettype wire

/* sim/tb_fourier_series_evaluator_core.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the Fourier series evaluator core.
module tb_fourier_series_evaluator_core;

  localparam int TERMS = 10;
  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT = 2000;
  // Indexes with no register behind them
  localparam logic [1:0] CFG_IDX_SPARE = 2'd2;
  localparam logic [1:0] CFG_IDX_LAST  = 2'd3;

  typedef struct {
    logic signed [47:0] value;
    logic               saturated;
  } series_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic op = fse_pkg::OP_WRITE;
  logic [3:0] term_slot = '0;
  logic signed [31:0] amplitude = '0;
  logic [31:0] frequency = '0;
  logic [31:0] phase_offset = '0;
  logic [31:0] time_req = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic done;
  logic signed [47:0] value;
  logic saturated;

  // Predictor state
  fse_pkg::term_t term_store [TERMS];
  logic signed [31:0] bias_reg = '0;
  logic signed [31:0] trend_reg = '0;

  series_result_t pending_results [$];
  int errors = 0;
  int n_writes = 0;
  int n_evals = 0;
  int n_results = 0;
  int n_clamped = 0;
  int idle_cycles = 0;
  bit no_gaps = 1'b0;

  fourier_series_evaluator_core #(.NUM_TERMS(TERMS)) i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op),
    .term_slot(term_slot), .amplitude(amplitude), .frequency(frequency),
    .phase_offset(phase_offset), .time_req(time_req), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .value(value), .saturated(saturated)
  );

  always #5 clk = ~clk;

  // Sine magnitude over one quarter turn, x in Q0.30, result Q1.30
  function automatic longint unsigned quarter_mag(longint unsigned x);
    longint unsigned u;
    longint unsigned p;
    u = (x * x) >> 30;
    p = 64'(fse_pkg::POLY_COEF[fse_pkg::NUM_COEF-1]);
    for (int k = fse_pkg::NUM_COEF - 2; k >= 0; k--)
      p = 64'(fse_pkg::POLY_COEF[k]) - ((p * u) >> 30);
    return (p * x) >> 30;
  endfunction

  // Sine of a Q0.32 turn angle, signed Q1.30
  function automatic longint turn_sine(logic [31:0] theta);
    longint unsigned x;
    longint m;
    x = 64'(theta[29:0]);
    if (theta[30]) x = 64'(fse_pkg::ONE_Q30) - x;
    m = longint'(quarter_mag(x));
    return theta[31] ? -m : m;
  endfunction

  // Amplitude times sine, rounded half away from zero to Q16.16
  function automatic longint scaled_term(longint amp, longint s);
    longint p;
    longint half;
    longint unit;
    p = amp * s;
    half = longint'(1) << 29;
    unit = longint'(1) << 30;
    if (p >= 0) return (p + half) / unit;
    return -((-p + half) / unit);
  endfunction

  // Series value at time t from the predictor's terms and registers
  function automatic series_result_t predict_series(logic [31:0] t);
    longint trend_part;
    longint sum;
    longint lim;
    longint vmax;
    logic [31:0] theta;
    series_result_t r;
    lim = 64'sh4000_0000_0000_0000;
    vmax = (longint'(1) << 47) - 1;
    trend_part = longint'(trend_reg) * longint'({32'b0, t});
    if (trend_part > lim) trend_part = lim;
    if (trend_part < -lim) trend_part = -lim;
    sum = longint'(bias_reg) + trend_part;
    for (int k = 0; k < TERMS; k++) begin
      theta = term_store[k].freq * t + term_store[k].phase;
      if (k % 2 == 0) theta = theta + fse_pkg::QUARTER_TURN;
      sum += scaled_term(longint'(term_store[k].amp), turn_sine(theta));
    end
    r.saturated = 1'b0;
    if (sum > vmax) begin
      sum = vmax;
      r.saturated = 1'b1;
    end else if (sum < -vmax - 1) begin
      sum = -vmax - 1;
      r.saturated = 1'b1;
    end
    r.value = sum[47:0];
    return r;
  endfunction

  // Send one request; a zero gap keeps start high from the previous one
  task automatic send_request(input logic o, input logic [3:0] slot,
                              input logic [31:0] a, input logic [31:0] f,
                              input logic [31:0] ph, input logic [31:0] t);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    op <= o;
    term_slot <= slot;
    amplitude <= a;
    frequency <= f;
    phase_offset <= ph;
    time_req <= t;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    if (o == fse_pkg::OP_EVAL) begin
      pending_results.push_back(predict_series(t));
      n_evals++;
    end else begin
      n_writes++;
      if (slot < TERMS) term_store[slot] = '{amp: a, freq: f, phase: ph};
    end
  endtask

  // Stop requests, let every expected result arrive, then let the core settle
  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(input logic [1:0] idx, input logic [31:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == fse_pkg::CFG_IDX_BIAS) bias_reg = data;
    else if (idx == fse_pkg::CFG_IDX_TREND) trend_reg = data;
  endtask

  task automatic set_config(input logic [31:0] b, input logic [31:0] tr);
    drain();
    write_config(fse_pkg::CFG_IDX_BIAS, b);
    write_config(fse_pkg::CFG_IDX_TREND, tr);
  endtask

  // Cleared store, term writes at field extremes, ignored slots
  task automatic test_directed_terms;
    send_request(fse_pkg::OP_EVAL, 4'd0, '0, '0, '0, 32'd0);
    send_request(fse_pkg::OP_EVAL, 4'd0, '0, '0, '0, 32'hFFFF_FFFF);
    send_request(fse_pkg::OP_WRITE, 4'd0, 32'sh0001_0000, 32'd0, 32'd0, '0);
    send_request(fse_pkg::OP_EVAL, 4'd0, '0, '0, '0, 32'd5);
    send_request(fse_pkg::OP_WRITE, 4'd1, 32'sh7FFF_FFFF, 32'h4000_0000, 32'd0, '0);
    send_request(fse_pkg::OP_EVAL, 4'd0, '0, '0, '0, 32'd1);
    send_request(fse_pkg::OP_WRITE, 4'd2, 32'sh8000_0000, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, '0);
    send_request(fse_pkg::OP_WRITE, 4'd9, 32'sh8000_0000, 32'h8000_0000,
                 32'hC000_0000, '0);
    send_request(fse_pkg::OP_EVAL, 4'd0, '0, '0, '0, 32'd3);
    // slots past the store are dropped
    send_request(fse_pkg::OP_WRITE, 4'd10, 32'sh7FFF_FFFF, 32'h1234_5678,
                 32'h9ABC_DEF0, '0);
    send_request(fse_pkg::OP_WRITE, 4'd15, 32'sh7FFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, '0);
    send_request(fse_pkg::OP_EVAL, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'd7);
    for (int k = 3; k < 9; k++)
      send_request(fse_pkg::OP_WRITE, 4'(k), $urandom, $urandom, $urandom, '0);
    send_request(fse_pkg::OP_EVAL, 4'd0, '0, '0, '0, 32'h8000_0000);
    send_request(fse_pkg::OP_EVAL, 4'd0, '0, '0, '0, 32'hFFFF_FFFF);
  endtask

  // Register extremes, both clamp directions, unknown indexes
  task automatic test_config_extremes;
    set_config(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_request(fse_pkg::OP_EVAL, 4'd0, '0, '0, '0, 32'hFFFF_FFFF);
    send_request(fse_pkg::OP_EVAL, 4'd0, '0, '0, '0, 32'd0);
    set_config(32'h8000_0000, 32'h8000_0000);
    send_request(fse_pkg::OP_EVAL, 4'd0, '0, '0, '0, 32'hFFFF_FFFF);
    send_request(fse_pkg::OP_EVAL, 4'd0, '0, '0, '0, 32'd1);
    drain();
    write_config(CFG_IDX_SPARE, 32'hFFFF_FFFF);
    write_config(CFG_IDX_LAST, 32'h5555_5555);
    send_request(fse_pkg::OP_EVAL, 4'd0, '0, '0, '0, 32'd100);
  endtask

  // Mixed writes and evaluations with random content
  task automatic test_random_mix(input int count);
    logic [31:0] a;
    logic [31:0] f;
    logic [31:0] t;
    logic [3:0] slot;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      slot = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(10, 15))
                                         : 4'($urandom_range(0, 9));
      case ($urandom_range(0, 3))
        0: a = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        1: a = 32'($signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000);
        default: a = $urandom;
      endcase
      f = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h00FF_FFFF);
      t = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1000);
      if ($urandom_range(0, 9) < 4)
        send_request(fse_pkg::OP_WRITE, slot, a, f, $urandom, $urandom);
      else
        send_request(fse_pkg::OP_EVAL, 4'($urandom), $urandom, $urandom, $urandom, t);
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    series_result_t exp_r;
    if (!rst && done) begin
      n_results++;
      if (saturated) n_clamped++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result value=%0d saturated=%0b", $time, value, saturated);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (value !== exp_r.value) begin
          $display("%0t: value expected %0d actual %0d", $time, exp_r.value, value);
          errors++;
        end
        if (saturated !== exp_r.saturated) begin
          $display("%0t: saturated expected %0b actual %0b", $time, exp_r.saturated,
                   saturated);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((start && !busy) || (cfg_valid && cfg_ready) || done || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    for (int k = 0; k < TERMS; k++) term_store[k] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_terms();
    test_config_extremes();
    set_config(32'h0000_0000, 32'h0000_0000);
    test_random_mix(120);
    set_config($urandom, 32'($signed($urandom_range(0, 32'h1_FFFF)) - 32'sh1_0000));
    test_random_mix(120);
    set_config(32'h7FFF_FFFF, 32'h0000_0001);
    test_random_mix(100);
    set_config(32'h8000_0000, 32'hFFFF_FFFF);
    test_random_mix(100);
    set_config($urandom, $urandom);
    test_random_mix(120);
    drain();
    if (pending_results.size() != 0) errors++;
    $display("Covered %0d term writes and %0d evaluations, %0d results checked,",
             n_writes, n_evals, n_results);
    $display("%0d of them clamped, over seven register settings.", n_clamped);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/fse_pkg.sv
rtl/fse_term_mem.sv
rtl/fse_term_pipe.sv
rtl/fourier_series_evaluator_core.sv
rtl/fse_checker.sv
sim/tb_fourier_series_evaluator_core.sv
